@@ hdl/mrcc_pkg.sv @@
// Package for the Modbus RTU reply checker: mode codes, CRC-16/MODBUS
// constants and the nibble-table byte step. No dependencies.
package mrcc_pkg;

  localparam logic MODE_BYTE    = 1'b0;  // rx_byte carries a received byte
  localparam logic MODE_RESTART = 1'b1;  // request sent, frame starts over

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Reflected poly 0xA001, four bits per lookup
  function automatic logic [15:0] nib_entry(input logic [3:0] idx);
    logic [15:0] val;
    case (idx)
      4'h0:    val = 16'h0000;
      4'h1:    val = 16'hCC01;
      4'h2:    val = 16'hD801;
      4'h3:    val = 16'h1400;
      4'h4:    val = 16'hF001;
      4'h5:    val = 16'h3C00;
      4'h6:    val = 16'h2800;
      4'h7:    val = 16'hE401;
      4'h8:    val = 16'hA001;
      4'h9:    val = 16'h6C00;
      4'hA:    val = 16'h7800;
      4'hB:    val = 16'hB401;
      4'hC:    val = 16'h5000;
      4'hD:    val = 16'h9C01;
      4'hE:    val = 16'h8801;
      4'hF:    val = 16'h4400;
      default: val = 16'h0000;
    endcase
    return val;
  endfunction

  // One byte through the CRC: xor in, then two nibble steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    c = (c >> 4) ^ nib_entry(c[3:0]);
    c = (c >> 4) ^ nib_entry(c[3:0]);
    return c;
  endfunction

endpackage

@@ hdl/modbus_reply_crc_checker.sv @@
// Modbus RTU reply checker: byte-wise CRC-16/MODBUS frame check with
// latched big-endian reading. Depends on mrcc_pkg.
//
//  channel | handshake           | word fields
//  --------+---------------------+------------------------------
//  in      | in_valid / in_ready | mode (1), rx_byte (8)
//  out     | out_valid/out_ready | crc_ok (1), reading (16)
//
// Each word takes effect at its accepting edge: the frame state (position,
// CRC, held bytes) updates there, and a completed frame loads the
// result register at that same edge. One word per cycle sustained; the
// only stall source is a full result register that is not being taken
// (in_ready = !out_valid || out_ready).
// Synchronous active-high rst puts the frame state at position 0, CRC
// 0xFFFF, held bytes and latched reading zero, and empties the result register.
module modbus_reply_crc_checker
  import mrcc_pkg::*;
#(
  parameter int FRAME_BYTES  = 7,
  parameter int BUFFER_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        crc_ok,
  output logic [15:0] reading
);

  // Position counts up to BUFFER_DEPTH itself before wrapping
  localparam int PW = $clog2(BUFFER_DEPTH + 1);
  // Compare width: holds position + 2 and FRAME_BYTES
  localparam int CW = ((PW > 6) ? PW : 6) + 1;
  localparam logic [CW-1:0] FRAME_C = CW'(FRAME_BYTES);
  localparam logic [PW-1:0] DEPTH_C = PW'(BUFFER_DEPTH);

  // Frame state
  logic [PW-1:0] byte_position, byte_position_next;
  logic [15:0]   running_crc, running_crc_next;
  logic [15:0]   payload_word, payload_word_next;
  logic [7:0]    check_low_byte, check_low_byte_next;
  logic [15:0]   last_reading, last_reading_next;

  logic          in_take;
  logic [PW-1:0] pos;        // position after buffer wrap
  logic [CW-1:0] pos_ext;
  logic [15:0]   crc_base;   // CRC restarts at byte 0
  logic          frame_done;
  logic          match;

  assign in_ready = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    pos      = (byte_position >= DEPTH_C) ? '0 : byte_position;
    pos_ext  = CW'(pos);
    crc_base = (pos == '0) ? CRC_INIT : running_crc;

    byte_position_next  = pos + PW'(1);
    running_crc_next    = crc_base;
    payload_word_next   = payload_word;
    check_low_byte_next = check_low_byte;

    if (pos_ext == CW'(3)) begin
      payload_word_next[15:8] = rx_byte;
    end else if (pos_ext == CW'(4)) begin
      payload_word_next[7:0] = rx_byte;
    end

    // Body bytes feed the CRC; the next-to-last byte is the check low byte
    if (pos_ext + CW'(2) < FRAME_C) begin
      running_crc_next = crc_byte(crc_base, rx_byte);
    end else if (pos_ext + CW'(2) == FRAME_C) begin
      check_low_byte_next = rx_byte;
    end

    frame_done = (pos_ext + CW'(1) == FRAME_C);
    match      = (running_crc_next == {rx_byte, check_low_byte_next});
    last_reading_next = (frame_done && match) ? payload_word_next : last_reading;

    if (mode == MODE_RESTART) begin
      byte_position_next  = '0;
      running_crc_next    = CRC_INIT;
      payload_word_next   = payload_word;
      check_low_byte_next = check_low_byte;
      last_reading_next   = last_reading;
      frame_done          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      running_crc    <= CRC_INIT;
      payload_word   <= '0;
      check_low_byte <= '0;
      last_reading   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_take) begin
        byte_position  <= byte_position_next;
        running_crc    <= running_crc_next;
        payload_word   <= payload_word_next;
        check_low_byte <= check_low_byte_next;
        last_reading   <= last_reading_next;
      end
      if (in_take && frame_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word, no reset needed
  always_ff @(posedge clk) begin
    if (in_take && frame_done) begin
      crc_ok  <= match;
      reading <= last_reading_next;
    end
  end

  // A restart word leaves a fresh frame behind
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    in_take && mode == MODE_RESTART |=> byte_position == '0 && running_crc == CRC_INIT)
    else $error("restart did not clear frame state");

  // Position never runs past the buffer depth
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= DEPTH_C)
    else $error("byte position beyond buffer depth");

  // A pending result always shows the latest good reading
  a_reading_current: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reading == last_reading)
    else $error("pending reading differs from latched reading");

endmodule
